>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Antecedent at one edge, consequent at the next edge.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/core/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// Widths, operation codes and error codes of the double-ended queue.
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int ERR_W   = 2;

    // operation codes; unused codes act as status only
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_STATUS     = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

endpackage

>>> rtl/core/deq_if.sv
// ---------------------------------------------------------------------------
// deq_if
// Valid/ready channels of the queue: request beats and response beats.
// ---------------------------------------------------------------------------
interface deq_req_if;
    logic                                    valid;
    logic                                    ready;
    logic        [deq_pkg::FUNC_W-1:0]       func;
    logic signed [deq_pkg::DATA_W-1:0]       data_value;

    modport source (output valid, output func, output data_value, input ready);
    modport sink   (input valid, input func, input data_value, output ready);
endinterface

interface deq_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [deq_pkg::DATA_W-1:0]       front_value;
    logic signed [deq_pkg::DATA_W-1:0]       back_value;
    logic                                    is_empty;
    logic                                    is_full;
    logic        [deq_pkg::COUNT_W-1:0]      entry_count;
    logic        [deq_pkg::ERR_W-1:0]        error_code;

    modport source (output valid, output front_value, output back_value,
                    output is_empty, output is_full, output entry_count,
                    output error_code, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input is_empty, input is_full, input entry_count,
                    input error_code, output ready);
endinterface

>>> rtl/core/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept as a ring in a RAM.
// ---------------------------------------------------------------------------
//  channel | dir | fields                                   | beat
//  --------+-----+------------------------------------------+------------------
//  req     | in  | func, data_value                         | one operation
//  rsp     | out | front_value, back_value, is_empty,       | one result per
//          |     | is_full, entry_count, error_code         | request
//
//  Steps per item with the response side free: accept (pointer update and
//  RAM write), read issue, response load. The RAM's registered read must
//  follow the write of the same item; no new request is taken meanwhile.
//  Reset: head and count clear; the entry RAM is not cleared (an empty
//  queue reports zero values). req.ready is high straight out of reset.
//  Stalls: a result waits in the output register while the next request is
//  accepted; that request holds in its response step until the slot frees.
// ---------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RESP} state_t;

    // control state
    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                head_reg, head_next;
    logic [CNT_W-1:0]                occ_reg, occ_next;
    logic [deq_pkg::ERR_W-1:0]       err_reg, err_next;

    // response register
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [deq_pkg::DATA_W-1:0]      front_reg, front_next;
    logic [deq_pkg::DATA_W-1:0]      back_reg, back_next;
    logic                            empty_reg, empty_next;
    logic                            full_reg, full_next;
    logic [deq_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [deq_pkg::ERR_W-1:0]       code_reg, code_next;

    // RAM side
    logic                            wr_en;
    logic [PTR_W-1:0]                wr_addr;
    logic                            rd_en;
    logic [PTR_W-1:0]                back_addr;
    logic [deq_pkg::DATA_W-1:0]      rd_front;
    logic [deq_pkg::DATA_W-1:0]      rd_back;

    // ring arithmetic
    logic                            accept;
    logic                            q_empty;
    logic                            q_full;
    logic [PTR_W-1:0]                head_dec;
    logic [PTR_W-1:0]                head_inc;
    logic [SUM_W-1:0]                tail_sum;
    logic [PTR_W-1:0]                tail_addr;
    logic [SUM_W-1:0]                back_sum;
    logic                            load_rsp;
    logic [CNT_W+deq_pkg::COUNT_W-1:0] count_wide;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign q_empty = (occ_reg == '0);
    assign q_full  = (occ_reg == CNT_FULL);

    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - PTR_W'(1);
    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);

    // slot past the back entry; only used when not full, so sum < 2*DEPTH
    assign tail_sum  = {1'b0, head_reg} + SUM_W'(occ_reg);
    assign tail_addr = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH)
                                               : PTR_W'(tail_sum);

    // back entry; only meaningful when occupied
    assign back_sum  = {1'b0, head_reg} + SUM_W'(occ_reg) - SUM_W'(1);
    assign back_addr = (back_sum >= SUM_DEPTH) ? PTR_W'(back_sum - SUM_DEPTH)
                                               : PTR_W'(back_sum);

    assign rd_en    = (state_reg == ST_READ);
    assign load_rsp = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp.ready);

    assign count_wide = (CNT_W + deq_pkg::COUNT_W)'(occ_reg);

    // operation decode and pointer update at accept
    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        err_next  = err_reg;
        wr_en     = 1'b0;
        wr_addr   = tail_addr;
        if (accept)
        begin
            err_next = deq_pkg::ERR_OK;
            unique case (req.func)
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (q_full)
                    begin
                        err_next = deq_pkg::ERR_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = head_dec;
                        head_next = head_dec;
                        occ_next  = occ_reg + CNT_W'(1);
                    end
                end
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (q_full)
                    begin
                        err_next = deq_pkg::ERR_FULL;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (q_empty)
                    begin
                        err_next = deq_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        head_next = head_inc;
                        occ_next  = occ_reg - CNT_W'(1);
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    if (q_empty)
                    begin
                        err_next = deq_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        occ_next = occ_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    // status only, also for unused codes
                    err_next = deq_pkg::ERR_OK;
                end
            endcase
        end
    end

    // sequencing and response register
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        code_next      = code_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (load_rsp)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    front_next     = q_empty ? '0 : rd_front;
                    back_next      = q_empty ? '0 : rd_back;
                    empty_next     = q_empty;
                    full_next      = q_full;
                    count_next     = count_wide[deq_pkg::COUNT_W-1:0];
                    code_next      = err_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            err_reg       <= deq_pkg::ERR_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            err_reg       <= err_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        empty_reg <= empty_next;
        full_reg  <= full_next;
        count_reg <= count_next;
        code_reg  <= code_next;
    end

    // front entry sits at head, back entry at head + count - 1
    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_deq_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (req.data_value),
        .rd_en     (rd_en),
        .rd_addr_a (head_reg),
        .rd_addr_b (back_addr),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.front_value = front_reg;
    assign rsp.back_value  = back_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.is_full     = full_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.error_code  = code_reg;

endmodule

>>> rtl/core/deq_ram.sv
// ---------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_W,
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> rtl/core/deq_check.sv
// ---------------------------------------------------------------------------
// deq_check
// Port-level checks of the queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [deq_pkg::DATA_W-1:0]        front_value,
    input logic [deq_pkg::DATA_W-1:0]        back_value,
    input logic                              is_empty,
    input logic                              is_full,
    input logic [deq_pkg::COUNT_W-1:0]       entry_count,
    input logic [deq_pkg::ERR_W-1:0]         error_code
);

    logic                          seen_reg;
    logic [deq_pkg::COUNT_W-1:0]   last_cnt_reg;
    logic [deq_pkg::COUNT_W-1:0]   cnt_step;
    logic                          rsp_beat;

    assign rsp_beat = rsp_valid && rsp_ready;
    assign cnt_step = entry_count - last_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_cnt_reg <= '0;
        end
        else if (rsp_beat)
        begin
            seen_reg     <= 1'b1;
            last_cnt_reg <= entry_count;
        end
    end

    // stalled result holds
    `DEQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(front_value) && $stable(back_value) && $stable(entry_count) && $stable(error_code))

    // one request in flight at a time
    `DEQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // error codes agree with the flags they imply
    `DEQ_ASSERT(a_err_flags, clk, rst_n, rsp_valid && (error_code == deq_pkg::ERR_EMPTY || error_code == deq_pkg::ERR_FULL) |-> (error_code == deq_pkg::ERR_EMPTY ? is_empty : is_full))

    // empty queue reports zero values and zero count
    `DEQ_ASSERT(a_empty_zero, clk, rst_n, rsp_valid && is_empty |-> front_value == '0 && back_value == '0 && entry_count == '0 && !is_full)

    // count moves by at most one entry between results
    `DEQ_ASSERT(a_count_step, clk, rst_n, rsp_beat && seen_reg |-> cnt_step == '0 || cnt_step == deq_pkg::COUNT_W'(1) || cnt_step == '1)

endmodule

bind double_ended_queue deq_check u_deq_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .front_value (rsp.front_value),
    .back_value  (rsp.back_value),
    .is_empty    (rsp.is_empty),
    .is_full     (rsp.is_full),
    .entry_count (rsp.entry_count),
    .error_code  (rsp.error_code)
);
